// ===== rtl/rcppm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcppm_pkg
// Shared types and constants for the RC PPM frame generator.
// ----------------------------------------------------------------------------
package rcppm_pkg;

	localparam int FL_W  = 16;
	localparam int SH_W  = 16;
	localparam int SEP_W = 10;
	localparam int CC_W  = 4;
	localparam int CH_W  = 3;
	localparam int WD_W  = 12;
	localparam int REM_W = 16;
	localparam int CFG_W = 16;

	localparam logic [FL_W-1:0]  FL_RST  = 16'd22500;
	localparam logic [SH_W-1:0]  SH_RST  = 16'd2000;
	localparam logic [SEP_W-1:0] SEP_RST = 10'd300;
	localparam logic [CC_W-1:0]  CC_RST  = 4'd8;
	localparam logic [WD_W-1:0]  WD_RST  = 12'd800;

	typedef enum logic [1:0] {
		CFG_FRAME_LEN     = 2'd0,
		CFG_START_HIGH    = 2'd1,
		CFG_SEPARATOR_LOW = 2'd2,
		CFG_CHANNEL_COUNT = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		PH_WAIT  = 4'b0001,
		PH_START = 4'b0010,
		PH_SEP   = 4'b0100,
		PH_CHAN  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [FL_W-1:0]  frame_len;
		logic [SH_W-1:0]  start_high;
		logic [SEP_W-1:0] separator_low;
		logic [CC_W-1:0]  channel_count;
	} cfg_t;

	typedef struct packed {
		logic level;
		logic frame_start;
	} ppm_out_t;

endpackage

// ===== rtl/rcppm_seq.sv =====
// ----------------------------------------------------------------------------
// rcppm_seq
// Frame sequencer: phase, slot, phase countdown and frame age. Zero-length
// phases are collapsed within the same tick.
// ----------------------------------------------------------------------------
module rcppm_seq import rcppm_pkg::*; #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               tick,
	input  cfg_t                               cfg,
	input  logic [MAX_CHANNELS-1:0][WD_W-1:0]  widths,
	output ppm_out_t                           result
);

	localparam int SLOT_W = $clog2(MAX_CHANNELS + 1);

	typedef struct packed {
		phase_t              phase;
		logic [SLOT_W-1:0]   slot;
		logic [REM_W-1:0]    rem;
	} pos_t;

	phase_t              phase_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [REM_W-1:0]    rem_q;
	logic [FL_W-1:0]     elapsed_q;

	logic                             sep_zero;
	logic [4:0]                       cc5;
	logic [4:0]                       act5;
	logic [SLOT_W-1:0]                act;
	logic [MAX_CHANNELS-1:0]          gt;
	logic [MAX_CHANNELS-1:0][WD_W-1:0] diff;
	pos_t                             start_pos;
	pos_t                             nxt;
	logic                             started;
	logic [REM_W-1:0]                 rem_n;
	logic [FL_W-1:0]                  elapsed_n;

	// Entry into a separator whose time is used up at slot s: next channel
	// with a nonzero high time, another separator, or the end-of-frame wait.
	function automatic pos_t resolve_sep(
		input logic [SLOT_W-1:0]               s,
		input logic [FL_W-1:0]                 el,
		input logic [SLOT_W-1:0]               a,
		input logic [MAX_CHANNELS-1:0]         g,
		input logic [MAX_CHANNELS-1:0][WD_W-1:0] d,
		input logic [SEP_W-1:0]                sep,
		input logic [FL_W-1:0]                 fl
	);
		pos_t              p;
		logic              found;
		logic [SLOT_W-1:0] sel;
		logic [WD_W-1:0]   dsel;
		found = 1'b0;
		sel   = s;
		dsel  = '0;
		for (int j = MAX_CHANNELS - 1; j >= 0; j--) begin
			if (SLOT_W'(j) >= s && SLOT_W'(j) < a && g[j] &&
			    (sep == '0 || SLOT_W'(j) == s)) begin
				found = 1'b1;
				sel   = SLOT_W'(j);
				dsel  = d[j];
			end
		end
		if (found) begin
			p.phase = PH_CHAN;
			p.slot  = sel;
			p.rem   = {{(REM_W-WD_W){1'b0}}, dsel};
		end else if (sep != '0 && s < a) begin
			p.phase = PH_SEP;
			p.slot  = s + 1'b1;
			p.rem   = {{(REM_W-SEP_W){1'b0}}, sep};
		end else begin
			p.phase = PH_WAIT;
			p.slot  = s;
			p.rem   = (fl > el) ? REM_W'(fl - el) : '0;
		end
		return p;
	endfunction

	assign sep_zero = (cfg.separator_low == '0);
	assign cc5      = {1'b0, cfg.channel_count};
	assign act5     = (cc5 > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : cc5;
	assign act      = act5[SLOT_W-1:0];

	always_comb begin
		for (int j = 0; j < MAX_CHANNELS; j++) begin
			gt[j]   = widths[j] > {{(WD_W-SEP_W){1'b0}}, cfg.separator_low};
			diff[j] = widths[j] - {{(WD_W-SEP_W){1'b0}}, cfg.separator_low};
		end
	end

	always_comb begin
		if (cfg.start_high != '0) begin
			start_pos.phase = PH_START;
			start_pos.slot  = '0;
			start_pos.rem   = cfg.start_high;
		end else if (!sep_zero) begin
			start_pos.phase = PH_SEP;
			start_pos.slot  = '0;
			start_pos.rem   = {{(REM_W-SEP_W){1'b0}}, cfg.separator_low};
		end else begin
			start_pos = resolve_sep('0, '0, act, gt, diff, cfg.separator_low,
				cfg.frame_len);
		end
	end

	always_comb begin
		started   = 1'b0;
		nxt.phase = phase_q;
		nxt.slot  = slot_q;
		nxt.rem   = rem_q;
		if (rem_q == '0) begin
			case (phase_q)
				PH_WAIT: begin
					started = 1'b1;
					nxt     = start_pos;
				end
				PH_START: begin
					if (!sep_zero) begin
						nxt.phase = PH_SEP;
						nxt.slot  = slot_q;
						nxt.rem   = {{(REM_W-SEP_W){1'b0}}, cfg.separator_low};
					end else begin
						nxt = resolve_sep(slot_q, elapsed_q, act, gt, diff,
							cfg.separator_low, cfg.frame_len);
					end
				end
				PH_SEP: begin
					nxt = resolve_sep(slot_q, elapsed_q, act, gt, diff,
						cfg.separator_low, cfg.frame_len);
				end
				PH_CHAN: begin
					if (!sep_zero) begin
						nxt.phase = PH_SEP;
						nxt.slot  = slot_q + 1'b1;
						nxt.rem   = {{(REM_W-SEP_W){1'b0}}, cfg.separator_low};
					end else begin
						nxt = resolve_sep(slot_q + 1'b1, elapsed_q, act, gt, diff,
							cfg.separator_low, cfg.frame_len);
					end
				end
				default: begin
					started = 1'b1;
					nxt     = start_pos;
				end
			endcase
			// overrun: frame already at or past its length, restart now
			if (!started && nxt.phase == PH_WAIT && nxt.rem == '0) begin
				started = 1'b1;
				nxt     = start_pos;
			end
		end
	end

	assign rem_n     = (nxt.rem != '0) ? nxt.rem - 1'b1 : '0;
	assign elapsed_n = started ? FL_W'(1) :
		((elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q);

	assign result.level       = (nxt.phase != PH_SEP);
	assign result.frame_start = started;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			slot_q    <= '0;
			rem_q     <= '0;
			elapsed_q <= '0;
		end else if (tick) begin
			phase_q   <= nxt.phase;
			slot_q    <= nxt.slot;
			rem_q     <= rem_n;
			elapsed_q <= elapsed_n;
		end
	end

	a_start_age: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && started) |=> (elapsed_q == FL_W'(1)))
		else $error("frame age not restarted on frame start");

	a_chan_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CHAN) |-> (int'(slot_q) < MAX_CHANNELS))
		else $error("channel phase with slot out of range");

	a_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && rem_q != '0) |=> (rem_q == $past(rem_q) - 1'b1))
		else $error("phase countdown slipped");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> ($stable(phase_q) && $stable(rem_q) && $stable(elapsed_q)))
		else $error("sequencer moved without a tick");

endmodule

// ===== rtl/rc_ppm_frame_generator_top.sv =====
// ----------------------------------------------------------------------------
// rc_ppm_frame_generator_top
// RC PPM pulse train generator: one output level per tick item, channel
// width writes between ticks, frame timing from the configuration registers.
// ----------------------------------------------------------------------------
// Pipeline: a tick item is captured in the input register and, once the output
// register is free or being read, its result is registered in the output register.
// Throughput: one item per cycle while the output is not stalled; set by the
// single-pass sequencer between the input register and the output register.
// Reset: asynchronous, active low; registers return to their defaults, widths
// to 800, and the first tick after reset starts a frame.
module rc_ppm_frame_generator_top import rcppm_pkg::*; #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,   // [2:0] channel, [14:3] width
	input  logic              s_axis_tuser,   // [0] op
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // [0] level
	output logic              m_axis_tuser    // [0] frame_start
);

	cfg_t                              cfg_q;
	logic [MAX_CHANNELS-1:0][WD_W-1:0] widths_q;

	logic              valid_s1;
	op_t               op_s1;
	logic [CH_W-1:0]   ch_s1;
	logic [WD_W-1:0]   wd_s1;

	logic              out_valid_q;
	ppm_out_t          out_q;

	logic              adv;
	logic              take;
	logic              tick;
	logic              wr;
	ppm_out_t          seq_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_len     <= FL_RST;
			cfg_q.start_high    <= SH_RST;
			cfg_q.separator_low <= SEP_RST;
			cfg_q.channel_count <= CC_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FRAME_LEN:     cfg_q.frame_len     <= cfg_data[FL_W-1:0];
				CFG_START_HIGH:    cfg_q.start_high    <= cfg_data[SH_W-1:0];
				CFG_SEPARATOR_LOW: cfg_q.separator_low <= cfg_data[SEP_W-1:0];
				CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[CC_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign tick          = valid_s1 && adv && (op_s1 == OP_TICK);
	assign wr            = valid_s1 && adv && (op_s1 == OP_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op_t'(s_axis_tuser);
			ch_s1 <= s_axis_tdata[CH_W-1:0];
			wd_s1 <= s_axis_tdata[CH_W+WD_W-1:CH_W];
		end
	end

	// writes beyond the channel table are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_CHANNELS; j++) begin
				widths_q[j] <= WD_RST;
			end
		end else if (wr) begin
			for (int j = 0; j < MAX_CHANNELS; j++) begin
				if (int'(ch_s1) == j) begin
					widths_q[j] <= wd_s1;
				end
			end
		end
	end

	rcppm_seq #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.cfg    (cfg_q),
		.widths (widths_q),
		.result (seq_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			out_q <= seq_out;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_q.level};
	assign m_axis_tuser  = out_q.frame_start;

	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> m_axis_tvalid)
		else $error("tick item produced no result");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && out_valid_q && !m_axis_tready) |=> m_axis_tvalid && $stable(out_q))
		else $error("width write disturbed the pending result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(out_q))
		else $error("pending result changed before it was taken");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: RC PPM frame generator testbench
// Drives tick and channel-width items into the stream input and checks the
// line level and frame-start flag of every result against a cycle-free model
// of the frame sequencer. Frame timing is set small so that many frames,
// overruns, empty frames and zero-length phases pass in a short run.
// ----------------------------------------------------------------------------
module tb_top import rcppm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH      = 8;
	localparam int IDLE_LIMIT  = 5000;
	localparam int MAX_REPORTS = 50;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;   // [2:0] channel, [14:3] width
	logic              s_axis_tuser = 1'b0; // [0] op
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;        // [0] level
	logic              m_axis_tuser;        // [0] frame_start

	rc_ppm_frame_generator_top #(.MAX_CHANNELS(NUM_CH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// frame sequencer model state
	cfg_t             seq_cfg;
	logic [WD_W-1:0]  slot_width [NUM_CH];
	logic [3:0]       slot_idx;
	phase_t           seq_phase;
	logic [REM_W-1:0] ticks_left;
	logic [15:0]      frame_ticks;

	ppm_out_t expected_levels[$];

	int src_idle_pct  = 0;
	int rcv_stall_pct = 0;
	int hold_request  = 0;
	int hold_left     = 0;
	int error_count   = 0;
	int tick_count    = 0;
	int width_writes  = 0;
	int levels_seen   = 0;
	int frames_seen   = 0;
	int idle_cycles   = 0;

	function automatic ppm_out_t advance_line_tick();
		ppm_out_t   r;
		logic       started;
		logic       stop;
		logic [3:0] active;
		logic [15:0] w;
		logic [15:0] sep;
		started = 1'b0;
		stop    = 1'b0;
		active  = (seq_cfg.channel_count > NUM_CH) ? 4'(NUM_CH) : seq_cfg.channel_count;
		sep     = 16'(seq_cfg.separator_low);
		while (ticks_left == 0 && !stop) begin
			case (seq_phase)
				PH_WAIT: begin
					if (started) begin
						stop = 1'b1;
					end else begin
						started     = 1'b1;
						frame_ticks = '0;
						slot_idx    = '0;
						seq_phase   = PH_START;
						ticks_left  = seq_cfg.start_high;
					end
				end
				PH_START: begin
					seq_phase  = PH_SEP;
					ticks_left = sep;
				end
				PH_SEP: begin
					if (slot_idx < active) begin
						w          = 16'(slot_width[slot_idx[2:0]]);
						seq_phase  = PH_CHAN;
						ticks_left = (w > sep) ? w - sep : 16'd0;
					end else begin
						seq_phase  = PH_WAIT;
						ticks_left = (frame_ticks < seq_cfg.frame_len) ?
							seq_cfg.frame_len - frame_ticks : 16'd0;
					end
				end
				default: begin
					slot_idx   = slot_idx + 4'd1;
					seq_phase  = PH_SEP;
					ticks_left = sep;
				end
			endcase
		end
		r.level       = (seq_phase != PH_SEP);
		r.frame_start = started;
		if (ticks_left > 0)
			ticks_left = ticks_left - 16'd1;
		if (frame_ticks != 16'hFFFF)
			frame_ticks = frame_ticks + 16'd1;
		return r;
	endfunction

	task automatic send_item(input op_t op, input logic [2:0] ch, input logic [WD_W-1:0] w);
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, w, ch};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_WRITE) begin
			slot_width[ch] = w;
			width_writes++;
		end else begin
			expected_levels.push_back(advance_line_tick());
			tick_count++;
		end
	endtask

	task automatic send_tick();
		send_item(OP_TICK, 3'($urandom_range(7)), 12'($urandom_range(4095)));
	endtask

	task automatic load_widths(input int max_w);
		for (int ch = 0; ch < NUM_CH; ch++)
			send_item(OP_WRITE, 3'(ch), 12'($urandom_range(max_w)));
	endtask

	task automatic drain_levels();
		s_axis_tvalid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
	endtask

	// register writes only once the pipeline has emptied, including trailing writes
	task automatic set_config(input logic [15:0] fl, input logic [15:0] sh,
			input logic [9:0] sep, input logic [3:0] cc);
		drain_levels();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FRAME_LEN;
		cfg_data  <= fl;
		@(posedge clk);
		cfg_index <= CFG_START_HIGH;
		cfg_data  <= sh;
		@(posedge clk);
		cfg_index <= CFG_SEPARATOR_LOW;
		cfg_data  <= 16'(sep);
		@(posedge clk);
		cfg_index <= CFG_CHANNEL_COUNT;
		cfg_data  <= 16'(cc);
		@(posedge clk);
		cfg_we <= 1'b0;
		seq_cfg.frame_len     = fl;
		seq_cfg.start_high    = sh;
		seq_cfg.separator_low = sep;
		seq_cfg.channel_count = cc;
	endtask

	task automatic send_random_item();
		logic [2:0] ch;
		int         active;
		if ($urandom_range(99) < 85) begin
			send_tick();
		end else begin
			ch     = 3'($urandom_range(NUM_CH - 1));
			active = (seq_cfg.channel_count > NUM_CH) ? NUM_CH : seq_cfg.channel_count;
			// wide values only on slots the frame does not read
			if (ch >= active)
				send_item(OP_WRITE, ch, 12'($urandom_range(4095)));
			else
				send_item(OP_WRITE, ch, 12'($urandom_range(20)));
		end
	endtask

	task automatic random_config();
		logic [15:0] fl;
		fl = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom_range(120));
		set_config(fl, 16'($urandom_range(8)), 10'($urandom_range(6)),
			4'($urandom_range(15)));
		load_widths(20);
	endtask

	// short width, zero high time, overrun, empty frame with no channels
	task automatic test_directed();
		set_config(16'd12, 16'd2, 10'd1, 4'd2);
		send_item(OP_WRITE, 3'd0, 12'd3);
		send_item(OP_WRITE, 3'd1, 12'd0);
		send_item(OP_WRITE, 3'd2, 12'd1);
		for (int ch = 3; ch < NUM_CH; ch++)
			send_item(OP_WRITE, 3'(ch), 12'hFFF);
		repeat (12) send_tick();
		set_config(16'd4, 16'd2, 10'd1, 4'd2);
		repeat (6) send_tick();
		set_config(16'd0, 16'd0, 10'd0, 4'd0);
		repeat (3) send_tick();
	endtask

	task automatic test_random_frames(input int n_items, input int src_pct, input int rcv_pct);
		random_config();
		src_idle_pct  = src_pct;
		rcv_stall_pct = rcv_pct;
		for (int i = 0; i < n_items; i++) begin
			send_random_item();
			if (i % 90 == 89)
				random_config();
		end
		src_idle_pct  = 0;
		rcv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		random_config();
		hold_request = 60;
		repeat (120) send_random_item();
		drain_levels();
		repeat (100) send_random_item();
	endtask

	task automatic test_extremes();
		set_config(16'hFFFF, 16'hFFFF, 10'h3FF, 4'hF);
		send_item(OP_WRITE, 3'd0, 12'hFFF);
		repeat (30) send_tick();
	endtask

	always @(posedge clk) begin : level_check
		ppm_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			levels_seen++;
			if (expected_levels.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$error("unexpected result: level %0b frame_start %0b",
						m_axis_tdata[0], m_axis_tuser);
			end else begin
				want = expected_levels.pop_front();
				if (want.frame_start)
					frames_seen++;
				if (m_axis_tdata[0] !== want.level) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("level: expected %0b, got %0b", want.level, m_axis_tdata[0]);
				end
				if (m_axis_tuser !== want.frame_start) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$error("frame_start: expected %0b, got %0b",
							want.frame_start, m_axis_tuser);
				end
			end
		end
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		seq_cfg.frame_len     = FL_RST;
		seq_cfg.start_high    = SH_RST;
		seq_cfg.separator_low = SEP_RST;
		seq_cfg.channel_count = CC_RST;
		for (int ch = 0; ch < NUM_CH; ch++)
			slot_width[ch] = WD_RST;
		slot_idx    = '0;
		seq_phase   = PH_WAIT;
		ticks_left  = '0;
		frame_ticks = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames(320, 0, 0);
		test_random_frames(320, 63, 0);
		test_random_frames(320, 0, 63);
		test_random_frames(320, 21, 21);
		test_backpressure();
		test_random_frames(300, 0, 0);
		test_extremes();

		drain_levels();
		repeat (8) @(posedge clk);
		$display("tb_top: %0d ticks, %0d width writes, %0d results, %0d frames started",
			tick_count, width_writes, levels_seen, frames_seen);
		$display("tb_top: covered overrun, empty frames, channel counts 0..15, idle mixes");
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
